// ===== sv/jse_pkg.sv =====
`default_nettype none
package jse_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [2:0] LEN_PLAIN = 3'd1;
    localparam logic [2:0] LEN_SHORT = 3'd2;
    localparam logic [2:0] LEN_UNI   = 3'd6;

    localparam logic [15:0] CAP_RESET = 16'd512;

    typedef struct packed {
        logic [2:0] len;
        logic [7:0] ch;
    } jse_esc_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_A + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/json_string_escape.sv =====
// An accepted byte is held in the input byte register, and its results go out through the output register.
// A pass-through byte gives one output character and an escaped byte 2 or 6, at
//   one character per cycle through the single output register unless m_tready stalls it.
// Bytes dropped after an overflow give no result.
// Reset (aresetn low, synchronous): clears count, drop mode and valid flags,
//   and loads the capacity with 512.
`default_nettype none
module json_string_escape #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,
    output logic [2:0]       m_tuser,   // [0] byte_valid, [1] string_done, [2] overflow
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import jse_pkg::*;

    logic [7:0]             byte_reg;
    logic                   in_valid_reg;
    logic [2:0]             idx_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   drop_reg;
    logic [15:0]            cap_reg;
    logic                   m_valid_reg;
    logic [7:0]             m_data_reg;
    logic                   m_last_reg;
    logic [2:0]             m_user_reg;

    jse_esc_t               esc;
    logic                   fits;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   term, silent, ovf, last_ch, out_free, produce, consume;

    jse_encode u_encode (
        .in_byte (byte_reg),
        .idx     (idx_reg),
        .esc     (esc)
    );

    jse_fit #(.COUNT_WIDTH(COUNT_WIDTH)) u_fit (
        .count      (count_reg),
        .len        (esc.len),
        .capacity   (cap_reg),
        .fits       (fits),
        .count_next (count_next)
    );

    always_comb begin
        term     = byte_reg == 8'd0;
        silent   = !term && drop_reg;
        ovf      = !term && !drop_reg && !fits;
        last_ch  = idx_reg == esc.len - 3'd1;
        out_free = !m_valid_reg || m_tready;
        produce  = in_valid_reg && out_free && !silent;
        consume  = in_valid_reg && (silent || (out_free && (term || ovf || last_ch)));
    end

    assign s_tready  = !in_valid_reg || consume;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;
    assign m_tuser   = m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            idx_reg      <= 3'd0;
            count_reg    <= '0;
            drop_reg     <= 1'b0;
            cap_reg      <= CAP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                idx_reg <= 3'd0;
                if (term) begin
                    count_reg <= '0;
                    drop_reg  <= 1'b0;
                end else if (ovf) begin
                    drop_reg <= 1'b1;
                end else if (!silent) begin
                    count_reg <= count_next;
                end
            end else if (produce) begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (produce) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
        if (produce) begin
            if (term) begin
                m_data_reg <= 8'd0;
                m_last_reg <= 1'b1;
                m_user_reg <= {drop_reg, 1'b1, 1'b0};
            end else if (ovf) begin
                m_data_reg <= 8'd0;
                m_last_reg <= 1'b1;
                m_user_reg <= 3'b100;
            end else begin
                m_data_reg <= esc.ch;
                m_last_reg <= last_ch;
                m_user_reg <= 3'b001;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/jse_encode.sv =====
`default_nettype none
module jse_encode (
    input  wire logic [7:0]       in_byte,
    input  wire logic [2:0]       idx,
    output jse_pkg::jse_esc_t     esc
);
    import jse_pkg::*;

    logic [7:0] second;
    logic [2:0] esc_len;
    logic [7:0] esc_ch;

    always_comb begin
        second = CH_BSLASH;
        esc_len = LEN_PLAIN;
        case (in_byte)
            CH_QUOTE: begin
                second = CH_QUOTE;
                esc_len = LEN_SHORT;
            end
            CH_BSLASH: begin
                second = CH_BSLASH;
                esc_len = LEN_SHORT;
            end
            CH_LF: begin
                second = CH_N;
                esc_len = LEN_SHORT;
            end
            CH_CR: begin
                second = CH_R;
                esc_len = LEN_SHORT;
            end
            CH_TAB: begin
                second = CH_T;
                esc_len = LEN_SHORT;
            end
            default: begin
                if (in_byte < CH_SPACE) begin
                    second = CH_U;
                    esc_len = LEN_UNI;
                end
            end
        endcase
    end

    always_comb begin
        if (esc_len == LEN_PLAIN) begin
            esc_ch = in_byte;
        end else begin
            case (idx)
                3'd0:    esc_ch = CH_BSLASH;
                3'd1:    esc_ch = second;
                3'd2:    esc_ch = CH_ZERO;
                3'd3:    esc_ch = CH_ZERO;
                3'd4:    esc_ch = hex_char(in_byte[7:4]);
                3'd5:    esc_ch = hex_char(in_byte[3:0]);
                default: esc_ch = CH_BSLASH;
            endcase
        end
    end

    assign esc = '{len: esc_len, ch: esc_ch};

endmodule
`default_nettype wire

// ===== sv/jse_fit.sv =====
`default_nettype none
module jse_fit #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic [COUNT_WIDTH-1:0] count,
    input  wire logic [2:0]             len,
    input  wire logic [15:0]            capacity,
    output logic                        fits,
    output logic [COUNT_WIDTH-1:0]      count_next
);
    localparam int SW = (COUNT_WIDTH + 1 > 17) ? COUNT_WIDTH + 1 : 17;
    localparam logic [SW-1:0] CMAX = SW'({COUNT_WIDTH{1'b1}});

    logic [SW-1:0] sum;

    always_comb begin
        sum = SW'(count) + SW'(len);
        fits = sum < SW'(capacity);
        count_next = (sum > CMAX) ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    end

endmodule
`default_nettype wire

// ===== sv/jse_checker.sv =====
`default_nettype none
module jse_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [2:0] m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && m_tdata == 8'd0)
        else $error("done item malformed");

    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1] && !m_tuser[2])
        else $error("character item carries status");

    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] && !m_tuser[1] |-> m_tlast && m_tdata == 8'd0)
        else $error("overflow item malformed");

endmodule

bind json_string_escape jse_checker u_jse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
